/* rtl/etsv_pkg.sv */
// ----------------------------------------------------------------------------
// etsv_pkg
// Shared types and constants for the escaped TSV record parser.
// ----------------------------------------------------------------------------
package etsv_pkg;

   localparam int CharWidth = 16;
   localparam int KindWidth = 2;

   localparam logic [CharWidth-1:0] CH_TAB = 16'h0009;
   localparam logic [CharWidth-1:0] CH_LF  = 16'h000A;
   localparam logic [CharWidth-1:0] CH_CR  = 16'h000D;
   localparam logic [CharWidth-1:0] CH_BSL = 16'h005C;
   localparam logic [CharWidth-1:0] CH_T   = 16'h0074;
   localparam logic [CharWidth-1:0] CH_R   = 16'h0072;
   localparam logic [CharWidth-1:0] CH_N   = 16'h006E;

   localparam logic [KindWidth-1:0] KIND_CHAR   = 2'd0;
   localparam logic [KindWidth-1:0] KIND_FIELD  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_RECORD = 2'd2;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam int FifoDepth = 4;
   localparam int PtrWidth  = $clog2(FifoDepth);
   localparam int CntWidth  = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [CharWidth-1:0] chr;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

endpackage

/* rtl/etsv_req_if.sv */
// ----------------------------------------------------------------------------
// etsv_req_if
// Input channel: one character or an end-of-content marker per transaction.
// ----------------------------------------------------------------------------
interface etsv_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [etsv_pkg::CharWidth-1:0]    in_char;

   modport source (output valid, output req_type, output in_char, input ready);
   modport sink   (input valid, input req_type, input in_char, output ready);
endinterface

/* rtl/etsv_rsp_if.sv */
// ----------------------------------------------------------------------------
// etsv_rsp_if
// Result channel: one decoded character or field/record end per transaction.
// ----------------------------------------------------------------------------
interface etsv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [etsv_pkg::KindWidth-1:0]    out_kind;
   logic [etsv_pkg::CharWidth-1:0]    out_char;
   logic                              last_of_run;

   modport source (output valid, output out_kind, output out_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_kind, input out_char, input last_of_run,
                   output ready);
endinterface

/* rtl/etsv_decode.sv */
// ----------------------------------------------------------------------------
// etsv_decode
// Parser state flags and the decode of one input transaction into up to two
// results.
// ----------------------------------------------------------------------------
module etsv_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           req_type,
   input  logic [etsv_pkg::CharWidth-1:0] in_char,
   output etsv_pkg::decode_type           decoded
);

   logic backslash_pending_ff, backslash_pending_in;
   logic after_cr_ff, after_cr_in;
   logic record_open_ff, record_open_in;

   etsv_pkg::result_type r0, r1;
   logic [1:0]           n;
   logic                 is_sep;

   always_comb begin
      r0 = '0;
      r1 = '0;
      n = 2'd0;
      backslash_pending_in = backslash_pending_ff;
      after_cr_in = after_cr_ff;
      record_open_in = record_open_ff;
      is_sep = (in_char == etsv_pkg::CH_CR) || (in_char == etsv_pkg::CH_LF) ||
               (in_char == etsv_pkg::CH_TAB);

      if (req_type == etsv_pkg::REQ_END) begin
         if (record_open_ff) begin
            if (backslash_pending_ff) begin
               r0.kind = etsv_pkg::KIND_CHAR;
               r0.chr = etsv_pkg::CH_BSL;
               r1.kind = etsv_pkg::KIND_RECORD;
               n = 2'd2;
            end else begin
               r0.kind = etsv_pkg::KIND_RECORD;
               n = 2'd1;
            end
         end
         backslash_pending_in = 1'b0;
         after_cr_in = 1'b0;
         record_open_in = 1'b0;
      end else if ((in_char == etsv_pkg::CH_LF) && after_cr_ff) begin
         after_cr_in = 1'b0;
      end else if (is_sep) begin
         if (backslash_pending_ff) begin
            r0.kind = etsv_pkg::KIND_CHAR;
            r0.chr = etsv_pkg::CH_BSL;
            r1.kind = (in_char == etsv_pkg::CH_TAB) ? etsv_pkg::KIND_FIELD
                                                   : etsv_pkg::KIND_RECORD;
            n = 2'd2;
         end else begin
            r0.kind = (in_char == etsv_pkg::CH_TAB) ? etsv_pkg::KIND_FIELD
                                                   : etsv_pkg::KIND_RECORD;
            n = 2'd1;
         end
         backslash_pending_in = 1'b0;
         record_open_in = (in_char == etsv_pkg::CH_TAB);
         after_cr_in = (in_char == etsv_pkg::CH_CR);
      end else begin
         after_cr_in = 1'b0;
         record_open_in = 1'b1;
         r0.kind = etsv_pkg::KIND_CHAR;
         if (backslash_pending_ff) begin
            backslash_pending_in = 1'b0;
            n = 2'd1;
            case (in_char)
               etsv_pkg::CH_T:   r0.chr = etsv_pkg::CH_TAB;
               etsv_pkg::CH_R:   r0.chr = etsv_pkg::CH_CR;
               etsv_pkg::CH_N:   r0.chr = etsv_pkg::CH_LF;
               etsv_pkg::CH_BSL: r0.chr = etsv_pkg::CH_BSL;
               default: begin
                  r0.chr = etsv_pkg::CH_BSL;
                  r1.kind = etsv_pkg::KIND_CHAR;
                  r1.chr = in_char;
                  n = 2'd2;
               end
            endcase
         end else if (in_char == etsv_pkg::CH_BSL) begin
            backslash_pending_in = 1'b1;
         end else begin
            r0.chr = in_char;
            n = 2'd1;
         end
      end

      r0.last = (n == 2'd1);
      r1.last = 1'b1;
      decoded.count = n;
      decoded.first = r0;
      decoded.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backslash_pending_ff <= 1'b0;
         after_cr_ff <= 1'b0;
         record_open_ff <= 1'b0;
      end else if (accept) begin
         backslash_pending_ff <= backslash_pending_in;
         after_cr_ff <= after_cr_in;
         record_open_ff <= record_open_in;
      end
   end

endmodule

/* rtl/escaped_tsv_record_parser_unit.sv */
// ----------------------------------------------------------------------------
// escaped_tsv_record_parser_unit
// Splits a character stream into TSV fields and records and undoes
// backslash escapes.
//
//   Channel | Direction | Payload
//   req     | in        | req_type, in_char
//   rsp     | out       | out_kind, out_char, last_of_run
//
// Each accepted transaction is decoded in the cycle it is accepted and its
// zero, one or two results are written into a four-entry result queue.
// Results leave the registered queue one per cycle while rsp.ready is high.
// A new transaction is accepted while the queue holds two results or fewer,
// so one character per cycle holds unless rsp stalls or two-result escapes pile up.
// Synchronous reset clears the parser flags and empties the queue.
// ----------------------------------------------------------------------------
module escaped_tsv_record_parser_unit (
   input  logic       clock,
   input  logic       reset,
   etsv_req_if.sink   req,
   etsv_rsp_if.source rsp
);

   etsv_pkg::decode_type decoded;
   etsv_pkg::result_type queue_ff [etsv_pkg::FifoDepth];
   etsv_pkg::result_type head;

   logic [etsv_pkg::PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [etsv_pkg::PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [etsv_pkg::CntWidth-1:0] count_ff, count_in;
   logic [etsv_pkg::PtrWidth-1:0] wr_next;
   logic                          accept;
   logic                          pop;

   assign req.ready = (count_ff <= etsv_pkg::CntWidth'(etsv_pkg::FifoDepth - 2));
   assign accept = req.valid && req.ready;

   etsv_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req.req_type),
      .in_char  (req.in_char),
      .decoded  (decoded)
   );

   assign head = queue_ff[rd_ptr_ff];
   assign rsp.valid = (count_ff != '0);
   assign rsp.out_kind = head.kind;
   assign rsp.out_char = head.chr;
   assign rsp.last_of_run = head.last;
   assign pop = rsp.valid && rsp.ready;

   assign wr_next = wr_ptr_ff + etsv_pkg::PtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + etsv_pkg::PtrWidth'(decoded.count);
         count_in = count_in + etsv_pkg::CntWidth'(decoded.count);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + etsv_pkg::PtrWidth'(1);
         count_in = count_in - etsv_pkg::CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (decoded.count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= decoded.first;
      end
      if (accept && (decoded.count == 2'd2)) begin
         queue_ff[wr_next] <= decoded.second;
      end
   end

   // The queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= etsv_pkg::CntWidth'(etsv_pkg::FifoDepth))
      else $error("result queue overflow");

   // A result that is not the last of its run is always followed by its partner.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !rsp.last_of_run) |=> rsp.valid)
      else $error("second result of a pair is missing");

   // Only defined kinds leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.out_kind == etsv_pkg::KIND_CHAR ||
                     rsp.out_kind == etsv_pkg::KIND_FIELD ||
                     rsp.out_kind == etsv_pkg::KIND_RECORD))
      else $error("undefined result kind");

   // Field and record ends carry a zero character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.out_kind != etsv_pkg::KIND_CHAR) |-> (rsp.out_char == '0))
      else $error("separator result carries a character");

endmodule
